/* rtl/hhp_pkg.sv */
// ----------------------------------------------------------------------------
// hhp_pkg
// Shared types and constants of the heading hold PID controller.
// ----------------------------------------------------------------------------
package hhp_pkg;

    localparam int HEAD_W  = 13;
    localparam int OUT_W   = 56;
    localparam int CFG_W   = 24;
    localparam int NUM_W   = 40;

    typedef enum logic [2:0] {
        CFG_PROP_GAIN  = 3'd0,
        CFG_INT_GAIN   = 3'd1,
        CFG_DERIV_GAIN = 3'd2,
        CFG_DEADBAND   = 3'd3,
        CFG_MIN_SPEED  = 3'd4,
        CFG_MAX_SPEED  = 3'd5,
        CFG_MAX_CORR   = 3'd6,
        CFG_INT_LIMIT  = 3'd7
    } t_cfg_idx;

endpackage

/* rtl/heading_hold_pid.sv */
// ----------------------------------------------------------------------------
// heading_hold_pid
// PID heading hold loop driving three motors, built on one shared multiplier
// and one shared bit-serial divider under a small sequencer.
// The derivative term comes from a 40-step division of the scaled error change
// by the elapsed time; heading errors out of range are first brought back with
// at most one wrap step. A release request skips the arithmetic and goes straight
// to the output state. One transaction at a time; a result waits in the output
// register while the next input is taken.
// Reset (synchronous, active low) restores register defaults and loop state.
// ----------------------------------------------------------------------------
module heading_hold_pid
    import hhp_pkg::*;
#(
    parameter int HEADING_STEPS = 5760,
    parameter int TIME_BITS     = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // target_heading, measured_heading, time_ms
    input  logic [((26 + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // action
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // m1_speed, m1_dir, m2_speed, m2_dir, m3_speed, m3_dir,
    // heading_error, correction, settled
    output logic [OUT_W-1:0]                        m_axis_tdata,
    input  logic                                    i_cfg_wr_en,
    input  logic [2:0]                              i_cfg_index,
    input  logic [CFG_W-1:0]                        i_cfg_data
);

    localparam int EW    = 18;
    localparam int DTC_W = 26;
    localparam int CW    = (TIME_BITS > DTC_W) ? TIME_BITS : DTC_W;
    localparam logic signed [EW-1:0] HS = EW'(HEADING_STEPS);
    localparam logic [DTC_W-1:0] DT_CAP = {1'b1, {(DTC_W - 1){1'b0}}};
    // ceil(2^34 / 1000) and ceil(2^36 / 1000)
    localparam logic [25:0] RCP_Q = 26'd17179870;
    localparam logic [30:0] RCP_R = 31'd68719477;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WRAP, ST_MEDT, ST_ACC, ST_MP, ST_MQ, ST_MR, ST_MR2,
        ST_MD1, ST_MD2, ST_DIVS, ST_DIVD, ST_SUM, ST_OUT
    } t_state;

    t_state r_state, n_state;

    logic [15:0] r_pg, r_ig, r_dg;
    logic [11:0] r_db;
    logic [7:0]  r_mins, r_maxs, r_mc;
    logic [23:0] r_lim;

    logic                  r_active;
    logic signed [13:0]    r_last_err;
    logic signed [24:0]    r_sum;
    logic [TIME_BITS-1:0]  r_last_time;

    logic signed [EW-1:0]  r_e;
    logic [TIME_BITS-1:0]  r_dt;
    logic signed [14:0]    r_de;
    logic [NUM_W-1:0]      r_prod;
    logic [14:0]           r_q;
    logic [9:0]            r_rem1;
    logic signed [30:0]    r_p;
    logic signed [40:0]    r_i, r_d;
    logic signed [24:0]    r_s;
    logic                  r_rel;
    logic [OUT_W-1:0]      r_tdata;
    logic                  r_tvalid;

    // input fields
    logic [HEAD_W-1:0]    in_tgt, in_meas;
    logic [TIME_BITS-1:0] in_time, base_time, dt_raw, dt_fix;
    assign in_tgt  = s_axis_tdata[12:0];
    assign in_meas = s_axis_tdata[25:13];
    assign in_time = s_axis_tdata[26 + TIME_BITS - 1:26];

    assign base_time = r_active ? r_last_time : in_time;
    assign dt_raw    = in_time - base_time;
    assign dt_fix    = (dt_raw <= TIME_BITS'(1)) ? TIME_BITS'(10) : dt_raw;

    logic              in_acc, out_free;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_tvalid || m_axis_tready;

    // derived operands
    logic              e_neg;
    logic [12:0]       e_abs;
    logic [CW-1:0]     dt_ext;
    logic [DTC_W-1:0]  dtc;
    logic [23:0]       sum_abs;
    logic [13:0]       de_abs;
    assign e_neg   = r_e[EW-1];
    assign e_abs   = e_neg ? 13'(-r_e) : 13'(r_e);
    assign dt_ext  = CW'(r_dt);
    assign dtc     = (dt_ext > CW'(DT_CAP)) ? DT_CAP : dt_ext[DTC_W-1:0];
    assign sum_abs = r_sum[24] ? 24'(-r_sum) : 24'(r_sum);
    assign de_abs  = r_de[14] ? 14'(-r_de) : 14'(r_de);

    // shared multiplier
    logic [30:0] mul_a;
    logic [25:0] mul_b;
    logic        mul_en;
    logic [56:0] mul_p;
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (r_state)
            ST_MEDT: begin mul_a = 31'(e_abs);   mul_b = dtc;            end
            ST_ACC:  begin mul_a = 31'(r_pg);    mul_b = 26'(e_abs);     end
            ST_MP:   begin mul_a = 31'(sum_abs); mul_b = RCP_Q;          end
            ST_MQ:   begin mul_a = 31'(r_ig);    mul_b = 26'(r_q);       end
            ST_MR:   begin mul_a = 31'(r_ig);    mul_b = 26'(r_rem1);    end
            ST_MR2:  begin mul_a = RCP_R;        mul_b = r_prod[25:0];   end
            ST_MD1:  begin mul_a = 31'(r_dg);    mul_b = 26'(de_abs);    end
            ST_MD2:  begin mul_a = r_prod[30:0]; mul_b = 26'd1000;       end
            default: mul_en = 1'b0;
        endcase
    end
    assign mul_p = 57'(mul_a) * 57'(mul_b);

    // integral term split as ig * q + (ig * r) / 1000, with sum = 1000 * q + r
    logic [24:0] q_thou;
    logic [23:0] rem_w;
    logic [40:0] i_mag;
    assign q_thou = 25'(r_q) * 25'd1000;
    assign rem_w  = sum_abs - q_thou[23:0];
    assign i_mag  = r_i + 41'(mul_p[52:36]);

    // shared divider
    logic                 div_start, div_done;
    logic [NUM_W-1:0]     div_q;
    assign div_start = (r_state == ST_DIVS);

    hhp_div #(.NW(NUM_W), .DW(TIME_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod),
        .i_den   (r_dt),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // integral accumulate and clamp
    logic signed [41:0] acc_w, lim_w;
    logic signed [24:0] sum_cl;
    assign lim_w = 42'(r_lim);
    assign acc_w = 42'(r_sum) + (e_neg ? -42'(r_prod) : 42'(r_prod));
    assign sum_cl = (acc_w > lim_w) ? 25'(lim_w) : ((acc_w < -lim_w) ? 25'(-lim_w) : 25'(acc_w));

    // PID sum saturation
    logic signed [42:0] s_w, smax_w;
    assign s_w    = 43'(r_p) + 43'(r_i) + 43'(r_d);
    assign smax_w = 43'({r_mc, 16'h0000});

    // output shaping
    logic        s_neg, settled;
    logic [23:0] s_abs;
    logic [7:0]  c_mag;
    logic [6:0]  v3_mag;
    logic [16:0] v3_prod;
    logic [8:0]  corr;
    logic [7:0]  sp1, sp3;
    logic [1:0]  dir1, dir2, dir3;
    assign s_neg   = r_s[24];
    assign s_abs   = s_neg ? 24'(-r_s) : 24'(r_s);
    assign c_mag   = s_abs[23:16];
    assign v3_prod = 17'(s_abs[23:15]) * 17'd205;
    assign v3_mag  = v3_prod[16:10];
    assign corr    = s_neg ? -{1'b0, c_mag} : {1'b0, c_mag};
    assign settled = ({1'b0, e_abs} < {2'b00, r_db});

    function automatic logic [7:0] shape(input logic [7:0] m, input logic [7:0] lo,
                                         input logic [7:0] hi);
        logic [7:0] v;
        v = m;
        if (v != 8'd0 && v < lo) v = lo;
        if (v > hi) v = hi;
        return v;
    endfunction

    assign sp1  = shape(c_mag, r_mins, r_maxs);
    assign sp3  = shape({1'b0, v3_mag}, r_mins, r_maxs);
    assign dir1 = (sp1 == 8'd0) ? 2'b00 : (s_neg ? 2'b11 : 2'b01);
    assign dir2 = (sp1 == 8'd0) ? 2'b00 : (s_neg ? 2'b01 : 2'b11);
    assign dir3 = (sp3 == 8'd0) ? 2'b00 : (s_neg ? 2'b11 : 2'b01);

    logic [OUT_W-1:0] res;
    always_comb begin
        res = '0;
        if (!r_rel) begin
            res[42:30] = r_e[12:0];
            res[51:43] = corr;
            res[52]    = settled;
            if (!settled) begin
                res[7:0]   = sp1;
                res[9:8]   = dir1;
                res[17:10] = sp1;
                res[19:18] = dir2;
                res[27:20] = sp3;
                res[29:28] = dir3;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = s_axis_tuser ? ST_OUT : ST_WRAP;
            ST_WRAP: if (!((r_e <<< 1) > HS) && !((r_e <<< 1) < -HS)) n_state = ST_MEDT;
            ST_MEDT: n_state = ST_ACC;
            ST_ACC:  n_state = ST_MP;
            ST_MP:   n_state = ST_MQ;
            ST_MQ:   n_state = ST_MR;
            ST_MR:   n_state = ST_MR2;
            ST_MR2:  n_state = ST_MD1;
            ST_MD1:  n_state = ST_MD2;
            ST_MD2:  n_state = ST_DIVS;
            ST_DIVS: n_state = ST_DIVD;
            ST_DIVD: if (div_done) n_state = ST_SUM;
            ST_SUM:  n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pg       <= 16'd1229;
            r_ig       <= 16'd205;
            r_dg       <= 16'd7373;
            r_db       <= 12'd48;
            r_mins     <= 8'd60;
            r_maxs     <= 8'd200;
            r_mc       <= 8'd150;
            r_lim      <= 24'd640000;
            r_active   <= 1'b0;
            r_last_err <= '0;
            r_sum      <= '0;
            r_last_time <= '0;
            r_tvalid   <= 1'b0;
            r_rel      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_PROP_GAIN:  r_pg   <= i_cfg_data[15:0];
                    CFG_INT_GAIN:   r_ig   <= i_cfg_data[15:0];
                    CFG_DERIV_GAIN: r_dg   <= i_cfg_data[15:0];
                    CFG_DEADBAND:   r_db   <= i_cfg_data[11:0];
                    CFG_MIN_SPEED:  r_mins <= i_cfg_data[7:0];
                    CFG_MAX_SPEED:  r_maxs <= i_cfg_data[7:0];
                    CFG_MAX_CORR:   r_mc   <= i_cfg_data[7:0];
                    CFG_INT_LIMIT:  r_lim  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && out_free) r_tvalid <= 1'b1;
            else if (m_axis_tready) r_tvalid <= 1'b0;
            if (mul_en) r_prod <= mul_p[NUM_W-1:0];
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_rel <= s_axis_tuser;
                        if (s_axis_tuser) begin
                            r_active <= 1'b0;
                        end else begin
                            r_active    <= 1'b1;
                            r_e         <= EW'({1'b0, in_tgt}) - EW'({1'b0, in_meas});
                            r_dt        <= dt_fix;
                            r_last_time <= in_time;
                            if (!r_active) begin
                                r_last_err <= '0;
                                r_sum      <= '0;
                            end
                        end
                    end
                end
                ST_WRAP: begin
                    if ((r_e <<< 1) > HS) r_e <= r_e - HS;
                    else if ((r_e <<< 1) < -HS) r_e <= r_e + HS;
                end
                ST_MEDT: begin
                    r_de       <= 15'(r_e) - 15'(r_last_err);
                    r_last_err <= 14'(r_e);
                end
                ST_ACC:  r_sum <= sum_cl;
                ST_MP: begin
                    r_p <= e_neg ? -31'(r_prod) : 31'(r_prod);
                    r_q <= mul_p[48:34];
                end
                ST_MQ:   r_rem1 <= rem_w[9:0];
                ST_MR:   r_i <= 41'(r_prod);
                ST_MR2:  r_i <= r_sum[24] ? -i_mag : i_mag;
                ST_DIVD: begin
                    if (div_done) r_d <= r_de[14] ? -41'(div_q) : 41'(div_q);
                end
                ST_SUM: begin
                    r_s <= (s_w > smax_w) ? 25'(smax_w)
                         : ((s_w < -smax_w) ? 25'(-smax_w) : 25'(s_w));
                end
                ST_OUT: begin
                    if (out_free) r_tdata <= res;
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;

endmodule

/* rtl/hhp_div.sv */
// ----------------------------------------------------------------------------
// hhp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hhp_div
    import hhp_pkg::*;
#(
    parameter int NW = 40,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DW:0] rem_sh;
    logic [DW:0] rem_sub;
    logic        q_bit;

    assign rem_sh  = {r_rem, r_quo[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_quo <= {r_quo[NW-2:0], q_bit};
                r_rem <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* rtl/hhp_check.sv */
// ----------------------------------------------------------------------------
// hhp_check
// Port-level checks of the heading hold PID controller.
// ----------------------------------------------------------------------------
module hhp_check
    import hhp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[52] |-> m_axis_tdata[29:0] == 30'd0)
        else $error("motors run while settled");

    a_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[7:0] == 8'd0) == (m_axis_tdata[9:8] == 2'b00))
                       && ((m_axis_tdata[27:20] == 8'd0) == (m_axis_tdata[29:28] == 2'b00)))
        else $error("speed and direction disagree");

endmodule

bind heading_hold_pid hhp_check u_hhp_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
